FILE: sv/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lzfgd_pkg.sv
// ---------------------------------------------------------------------------
// lzfgd_pkg
// Shared types and constants of the flag-group LZ decompressor.
// ---------------------------------------------------------------------------
package lzfgd_pkg;

    // history store, depth is a power of two
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int DIST_W = 12;
    localparam int CNT_W  = 24;
    localparam int LEN_W  = 17;
    localparam int ITEM_W = 4;
    localparam int HDR_W  = 3;

    localparam logic [CNT_W-1:0]  COUNT_MAX   = 24'hFF_FFFF;
    localparam logic [HDR_W-1:0]  HDR_LAST    = 3'd7;
    localparam logic [ITEM_W-1:0] GROUP_ITEMS = 4'd8;

    // length codes with extension bytes
    localparam logic [3:0] LEN_EXT1 = 4'h0;
    localparam logic [3:0] LEN_EXT2 = 4'h1;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_INPUT_LIMIT = 1'b0;

    // result item layout
    localparam int OUT_DATA_W   = 16;
    localparam int OUT_BUSY_BIT = 8;
    localparam int OUT_FIN_BIT  = 9;
    localparam int OUT_MIS_BIT  = 10;

    typedef enum logic [0:0] {
        OP_DATA = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_FLAG   = 8'b0000_0010,
        PH_ITEM   = 8'b0000_0100,
        PH_TOK1   = 8'b0000_1000,
        PH_TOK2   = 8'b0001_0000,
        PH_TOK3   = 8'b0010_0000,
        PH_COPY   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    // what the parser hands to the history stage for one item
    typedef struct packed {
        logic               emit;
        logic               from_hist;
        logic [7:0]         lit;
        logic [HIST_AW-1:0] waddr;
        logic [HIST_AW-1:0] raddr;
        logic               busy;
        logic               fin;
        logic               misuse;
    } t_step;

endpackage

FILE: sv/lzfgd_ram.sv
// ---------------------------------------------------------------------------
// lzfgd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module lzfgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lzfgd_ctrl.sv
// ---------------------------------------------------------------------------
// lzfgd_ctrl
// Stream parser: header skip, flag groups, match tokens and copy sequencing.
// ---------------------------------------------------------------------------
module lzfgd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  lzfgd_pkg::t_op                i_opcode,
    input  logic [7:0]                    i_byte,
    input  logic [lzfgd_pkg::CNT_W-1:0]   i_limit,
    output lzfgd_pkg::t_step              o_step
);
    import lzfgd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [HIST_AW-1:0]  r_wp, n_wp;
    logic [7:0]          r_flags, n_flags;
    logic [ITEM_W-1:0]   r_items, n_items;
    logic [HDR_W-1:0]    r_hdr, n_hdr;
    logic [7:0]          r_tok0, n_tok0;
    logic [7:0]          r_tok2, n_tok2;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_done, n_done;

    logic                data_ok;
    logic                limit_hit;
    logic [DIST_W-1:0]   tok_dist;
    logic [LEN_W-1:0]    rem_dec;
    t_step               step;

    // a stream byte is taken only outside a copy and before the end
    assign data_ok = (i_opcode == OP_DATA) && (r_phase != PH_COPY) &&
                     (r_phase != PH_DONE) && !r_done;

    // saturating input count and the limit test at a group boundary
    assign n_count   = (i_accept && data_ok && (r_count != COUNT_MAX))
                       ? r_count + CNT_W'(1) : r_count;
    assign limit_hit = (n_count >= i_limit);

    assign tok_dist = {i_byte, r_tok0[7:4]};
    assign rem_dec  = (r_rem != '0) ? r_rem - LEN_W'(1) : r_rem;

    // next-state logic of the parser
    always_comb begin
        n_phase = r_phase;
        n_wp    = r_wp;
        n_flags = r_flags;
        n_items = r_items;
        n_hdr   = r_hdr;
        n_tok0  = r_tok0;
        n_tok2  = r_tok2;
        n_rem   = r_rem;
        n_dist  = r_dist;
        n_done  = r_done;

        step           = '0;
        step.lit       = i_byte;
        step.waddr     = r_wp;
        step.raddr     = r_wp - HIST_AW'(r_dist);

        if (i_accept) begin
            if (i_opcode == OP_TICK) begin
                // copy tick: one history byte per tick
                if (r_phase == PH_COPY) begin
                    step.emit      = 1'b1;
                    step.from_hist = 1'b1;
                    n_wp           = r_wp + HIST_AW'(1);
                    n_rem          = rem_dec;
                    if (rem_dec == '0) begin
                        if (r_items != '0) begin
                            n_phase = PH_ITEM;
                        end else if (limit_hit) begin
                            n_phase = PH_DONE;
                            n_done  = 1'b1;
                        end else begin
                            n_phase = PH_FLAG;
                        end
                    end
                end
            end else if (!data_ok) begin
                step.misuse = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_hdr >= HDR_LAST) begin
                            if (limit_hit) begin
                                n_phase = PH_DONE;
                                n_done  = 1'b1;
                            end else begin
                                n_phase = PH_FLAG;
                            end
                        end else begin
                            n_hdr = r_hdr + HDR_W'(1);
                        end
                    end
                    PH_FLAG: begin
                        n_flags = 8'd0 - i_byte;
                        n_items = GROUP_ITEMS;
                        n_phase = PH_ITEM;
                    end
                    PH_ITEM: begin
                        n_flags = {r_flags[6:0], 1'b0};
                        n_items = (r_items != '0) ? r_items - ITEM_W'(1) : r_items;
                        if (r_flags[7]) begin
                            n_tok0  = i_byte;
                            n_phase = PH_TOK1;
                        end else begin
                            step.emit = 1'b1;
                            n_wp      = r_wp + HIST_AW'(1);
                            if (n_items != '0) begin
                                n_phase = PH_ITEM;
                            end else if (limit_hit) begin
                                n_phase = PH_DONE;
                                n_done  = 1'b1;
                            end else begin
                                n_phase = PH_FLAG;
                            end
                        end
                    end
                    PH_TOK1: begin
                        // zero distance is the end token
                        if (tok_dist == '0) begin
                            n_phase = PH_DONE;
                            n_done  = 1'b1;
                        end else begin
                            n_dist = tok_dist;
                            if (r_tok0[3:0] == LEN_EXT1 || r_tok0[3:0] == LEN_EXT2) begin
                                n_phase = PH_TOK2;
                            end else begin
                                n_rem   = LEN_W'(r_tok0[3:0]);
                                n_phase = PH_COPY;
                            end
                        end
                    end
                    PH_TOK2: begin
                        n_tok2 = i_byte;
                        if (r_tok0[3:0] == LEN_EXT1) begin
                            n_rem   = LEN_W'(i_byte) + LEN_W'(16);
                            n_phase = PH_COPY;
                        end else begin
                            n_phase = PH_TOK3;
                        end
                    end
                    PH_TOK3: begin
                        n_rem   = LEN_W'(r_tok2) + LEN_W'(17) + LEN_W'({i_byte, 8'hFF});
                        n_phase = PH_COPY;
                    end
                    default: begin
                    end
                endcase
            end
        end

        step.busy = (n_phase == PH_COPY);
        step.fin  = n_done;
    end

    assign o_step = step;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_wp    <= '0;
            r_flags <= '0;
            r_items <= '0;
            r_hdr   <= '0;
            r_tok0  <= '0;
            r_tok2  <= '0;
            r_rem   <= '0;
            r_dist  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_flags <= n_flags;
            r_items <= n_items;
            r_hdr   <= n_hdr;
            r_tok0  <= n_tok0;
            r_tok2  <= n_tok2;
            r_rem   <= n_rem;
            r_dist  <= n_dist;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

endmodule

FILE: sv/lz_flag_group_decompressor.sv
// ---------------------------------------------------------------------------
// lz_flag_group_decompressor
// Flag-group LZ decompressor with a 4096-byte history and an APB limit register.
// ---------------------------------------------------------------------------
// Usage
//   Input items arrive on the s channel: tuser selects a compressed byte in
//   tdata or a tick that moves a pending match copy by one byte. Every input
//   item gives exactly one result item on the m channel: a decompressed byte
//   with its valid flag in tuser, plus copy-busy, finished and misuse status.
//   The parser updates its state in the cycle of acceptance and issues the
//   history read; the history stage writes the produced byte back into history
//   as it advances, with forwarding when a match of distance one reads the byte
//   just made. A result is registered in the history stage and then in the
//   output register before it appears on the m channel.
//   Throughput: one item per cycle while the receiver keeps up, set by the
//   single history read and write port pair; a copy of n bytes needs n ticks.
//   Reset clears the parser, the pipeline and the input limit; history holds
//   no reset value. When the receiver stalls, the output register holds its
//   result and one more item may be accepted into the history stage; then
//   o_s_tready drops until the output moves.
//   input_limit is written at byte address 0 through the APB port.
// ---------------------------------------------------------------------------
module lz_flag_group_decompressor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] in_byte
    input  logic                            i_s_tuser,   // [0] opcode
    // result item
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] out_byte, [8] copy_busy, [9] finished, [10] misuse, [15:11] zero
    output logic [lzfgd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tuser,   // [0] out_valid
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lzfgd_pkg::PADDR_W-1:0]   paddr,
    input  logic [lzfgd_pkg::PDATA_W-1:0]   pwdata,
    output logic [lzfgd_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import lzfgd_pkg::*;

    logic [CNT_W-1:0]   r_limit;
    logic               cfg_sel;

    logic               in_acc;
    logic               out_adv;
    logic               s1_adv;
    t_step              step;

    logic               r_s1_valid;
    t_step              r_s1;
    logic               r_s1_fwd_hit;
    logic [7:0]         r_s1_fwd;
    logic [7:0]         ram_rdata;
    logic [7:0]         s1_byte;
    logic               ram_we;

    logic               r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic               r_o_user;

    // configuration register
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1] == REG_INPUT_LIMIT);
    assign prdata  = cfg_sel ? PDATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_limit <= pwdata[CNT_W-1:0];
        end
    end

    // handshake and stage movement
    assign out_adv    = !r_o_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_adv;
    assign o_s_tready = !r_s1_valid || out_adv;
    assign in_acc     = i_s_tvalid && o_s_tready;

    lzfgd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_opcode (t_op'(i_s_tuser)),
        .i_byte   (i_s_tdata),
        .i_limit  (r_limit),
        .o_step   (step)
    );

    // byte produced by the history stage
    always_comb begin
        if (!r_s1.emit) begin
            s1_byte = 8'd0;
        end else if (!r_s1.from_hist) begin
            s1_byte = r_s1.lit;
        end else if (r_s1_fwd_hit) begin
            s1_byte = r_s1_fwd;
        end else begin
            s1_byte = ram_rdata;
        end
    end

    assign ram_we = s1_adv && r_s1.emit;

    lzfgd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.waddr),
        .i_wdata (s1_byte),
        .i_re    (in_acc),
        .i_raddr (step.raddr),
        .o_rdata (ram_rdata)
    );

    // history stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // history stage payload, forward the byte written in the same cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1         <= step;
            r_s1_fwd_hit <= ram_we && (r_s1.waddr == step.raddr);
            r_s1_fwd     <= s1_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_o_data <= OUT_DATA_W'({r_s1.misuse, r_s1.fin, r_s1.busy, s1_byte});
            r_o_user <= r_s1.emit;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

endmodule

FILE: sv/lzfgd_chk.sv
// ---------------------------------------------------------------------------
// lzfgd_chk
// Port-level checks on the result channel of the decompressor.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lzfgd_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [lzfgd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                             o_m_tuser
);
    import lzfgd_pkg::*;

    logic r_seen_fin;
    logic out_acc;

    assign out_acc = o_m_tvalid && i_m_tready;

    // remembers that a delivered item already reported the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fin <= 1'b0;
        end else if (out_acc && o_m_tdata[OUT_FIN_BIT]) begin
            r_seen_fin <= 1'b1;
        end
    end

    // stalled result holds
    `LZ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    // finished stays set once reported
    `LZ_ASSERT_IMP(a_fin_sticky, i_clk, i_rst_n, o_m_tvalid && r_seen_fin,
        o_m_tdata[OUT_FIN_BIT], "finished dropped")

    // nothing is produced and no copy runs after the end
    `LZ_ASSERT_IMP(a_quiet_after_fin, i_clk, i_rst_n, o_m_tvalid && r_seen_fin,
        !o_m_tuser && !o_m_tdata[OUT_BUSY_BIT], "byte produced after finish")

    // an ignored byte never produces output, and empty items carry a zero byte
    `LZ_ASSERT_IMP(a_empty_item, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tdata[OUT_MIS_BIT] || !o_m_tuser),
        !o_m_tuser && (o_m_tdata[7:0] == 8'd0), "bad empty result")

endmodule

bind lz_flag_group_decompressor lzfgd_chk u_lzfgd_chk (.*);

FILE: tb/tb_lz_flag_group_decompressor.sv
// ---------------------------------------------------------------------------
// tb_lz_flag_group_decompressor
// Self-checking bench for the flag-group LZ decompressor. A local decoder
// tracks header, flag groups, tokens and copies, and predicts every result
// item. The stream generator reads that decoder's state, so the compressed
// streams are well formed: matches never reach back past the bytes produced
// so far. Stray ticks and out-of-turn bytes are mixed in as noise. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_lz_flag_group_decompressor;
    timeunit 1ns;
    timeprecision 1ps;

    import lzfgd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 100;

    // one predicted result item
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       busy;
        logic       fin;
        logic       misuse;
    } t_decoded;

    logic                    i_clk;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [7:0]              i_s_tdata  = '0;
    logic                    i_s_tuser  = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_tdata;   // [7:0] out_byte, [8] busy, [9] fin, [10] misuse
    logic                    o_m_tuser;   // [0] out_valid
    logic                    psel       = 1'b0;
    logic                    penable    = 1'b0;
    logic                    pwrite     = 1'b0;
    logic [PADDR_W-1:0]      paddr      = '0;
    logic [PDATA_W-1:0]      pwdata     = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    lz_flag_group_decompressor u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // local decoder state
    logic [7:0]         dec_hist [HIST_DEPTH];
    logic [HIST_AW-1:0] dec_wp        = '0;
    logic [7:0]         dec_flags     = '0;
    logic [ITEM_W-1:0]  dec_left      = '0;
    t_phase             dec_phase     = PH_HEADER;
    logic [HDR_W-1:0]   dec_hdr       = '0;
    logic [7:0]         dec_tok [3]   = '{8'd0, 8'd0, 8'd0};
    logic [LEN_W-1:0]   dec_copy_left = '0;
    logic [DIST_W-1:0]  dec_dist      = '0;
    logic [CNT_W-1:0]   dec_count     = '0;
    logic               dec_done      = 1'b0;
    logic [CNT_W-1:0]   cur_limit     = '0;
    int                 hist_filled   = 0;

    t_decoded decoded_q[$];

    // stream generator state
    logic [7:0] tok_hi  = '0;
    logic [7:0] ext_lo  = '0;
    logic [7:0] ext_hi  = '0;
    bit         end_mode = 1'b0;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_request = 1'b0;

    int n_sent    = 0;
    int n_checked = 0;
    int n_lit     = 0;
    int n_copied  = 0;
    int n_ignored = 0;
    int n_errors  = 0;
    string end_reason = "end token";

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function automatic void group_edge();
        if (dec_count >= cur_limit) begin
            dec_done  = 1'b1;
            dec_phase = PH_DONE;
        end else begin
            dec_phase = PH_FLAG;
        end
    endfunction

    function automatic void item_done();
        if (dec_left == '0) group_edge();
        else dec_phase = PH_ITEM;
    endfunction

    function automatic void hist_push(input logic [7:0] v);
        dec_hist[dec_wp] = v;
        dec_wp = dec_wp + 1'b1;
        if (hist_filled < HIST_DEPTH) hist_filled++;
    endfunction

    function automatic t_decoded decode_step(input t_op op, input logic [7:0] b);
        t_decoded           r;
        logic [DIST_W-1:0]  d;
        logic [HIST_AW-1:0] src;
        logic               is_match;
        r = '0;
        if (op == OP_TICK) begin
            // a tick only matters while a copy is pending
            if (dec_phase == PH_COPY) begin
                src = dec_wp - dec_dist;
                r.data  = dec_hist[src];
                r.valid = 1'b1;
                hist_push(r.data);
                n_copied++;
                if (dec_copy_left != '0) dec_copy_left--;
                if (dec_copy_left == '0) item_done();
            end
        end else if (dec_phase == PH_COPY || dec_phase == PH_DONE || dec_done) begin
            r.misuse = 1'b1;
            n_ignored++;
        end else begin
            if (dec_count != COUNT_MAX) dec_count++;
            case (dec_phase)
                PH_HEADER: begin
                    if (dec_hdr == HDR_LAST) group_edge();
                    else dec_hdr++;
                end
                PH_FLAG: begin
                    dec_flags = 8'd0 - b;
                    dec_left  = GROUP_ITEMS;
                    dec_phase = PH_ITEM;
                end
                PH_ITEM: begin
                    is_match  = dec_flags[7];
                    dec_flags = dec_flags << 1;
                    if (dec_left != '0) dec_left--;
                    if (is_match) begin
                        dec_tok[0] = b;
                        dec_phase  = PH_TOK1;
                    end else begin
                        r.data  = b;
                        r.valid = 1'b1;
                        hist_push(b);
                        n_lit++;
                        item_done();
                    end
                end
                PH_TOK1: begin
                    d = {b, dec_tok[0][7:4]};
                    dec_tok[1] = b;
                    // zero distance is the end token
                    if (d == '0) begin
                        dec_done  = 1'b1;
                        dec_phase = PH_DONE;
                    end else begin
                        dec_dist = d;
                        if (dec_tok[0][3:0] > LEN_EXT2) begin
                            dec_copy_left = {13'd0, dec_tok[0][3:0]};
                            dec_phase     = PH_COPY;
                        end else begin
                            dec_phase = PH_TOK2;
                        end
                    end
                end
                PH_TOK2: begin
                    dec_tok[2] = b;
                    if (dec_tok[0][3:0] == LEN_EXT1) begin
                        dec_copy_left = {9'd0, b} + 17'd16;
                        dec_phase     = PH_COPY;
                    end else begin
                        dec_phase = PH_TOK3;
                    end
                end
                PH_TOK3: begin
                    dec_copy_left = {9'd0, dec_tok[2]} + 17'd17 + {1'b0, b, 8'hFF};
                    dec_phase     = PH_COPY;
                end
                default: ;
            endcase
        end
        r.busy = (dec_phase == PH_COPY);
        r.fin  = dec_done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: leaves tvalid high so back-to-back items need one assignment
    // ------------------------------------------------------------------
    task automatic send_item(input t_op op, input logic [7:0] b);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        decoded_q.push_back(decode_step(op, b));
        n_sent++;
    endtask

    // tick until the pending copy is used up
    task automatic drain_copy();
        while (dec_phase == PH_COPY) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // let every result come out before touching the register
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INPUT_LIMIT, 2'b00};
        pwdata  <= {{(PDATA_W - CNT_W){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_limit  = v;
    endtask

    // next item of a well-formed stream, with some stray traffic mixed in
    task automatic send_next(input int noise_pct);
        logic [DIST_W-1:0] m_dist;
        logic [3:0]        code;
        logic [7:0]        pat;
        int                reach;
        int                pick;
        if ($urandom_range(0, 99) < noise_pct) begin
            // stray byte while copying is ignored, stray tick elsewhere does nothing
            if (dec_phase == PH_COPY) send_item(OP_DATA, 8'($urandom_range(0, 255)));
            else send_item(OP_TICK, 8'($urandom_range(0, 255)));
        end else begin
            case (dec_phase)
                PH_FLAG: begin
                    pat = 8'($urandom_range(0, 255));
                    if (hist_filled == 0) pat[7] = 1'b0;
                    else if (end_mode) pat[7] = 1'b1;
                    send_item(OP_DATA, 8'd0 - pat);
                end
                PH_ITEM: begin
                    if (!dec_flags[7]) begin
                        send_item(OP_DATA, 8'($urandom_range(0, 255)));
                    end else begin
                        reach = (hist_filled < 4095) ? hist_filled : 4095;
                        if (end_mode) m_dist = '0;
                        else if ($urandom_range(0, 3) == 0)
                            m_dist = DIST_W'($urandom_range(1, reach));
                        else m_dist = DIST_W'($urandom_range(1, (reach < 16) ? reach : 16));
                        pick = $urandom_range(0, 63);
                        if (pick == 0) code = LEN_EXT2;
                        else if (pick < 4) code = LEN_EXT1;
                        else code = 4'($urandom_range(2, 15));
                        tok_hi = m_dist[11:4];
                        ext_lo = 8'($urandom_range(0, 255));
                        ext_hi = (code == LEN_EXT2) ? 8'($urandom_range(0, 1)) : 8'd0;
                        send_item(OP_DATA, {m_dist[3:0], code});
                    end
                end
                PH_TOK1: send_item(OP_DATA, tok_hi);
                PH_TOK2: send_item(OP_DATA, ext_lo);
                PH_TOK3: send_item(OP_DATA, ext_hi);
                PH_COPY: send_item(OP_TICK, 8'($urandom_range(0, 255)));
                default: send_item(OP_DATA, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_header_and_literals();
        write_limit(COUNT_MAX);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'hA5);
        send_item(OP_DATA, 8'h5A);
        send_item(OP_DATA, 8'h01);
        send_item(OP_DATA, 8'h80);
        send_item(OP_DATA, 8'h7F);
        send_item(OP_DATA, 8'hFE);
        // zero flag byte: eight literals
        send_item(OP_DATA, 8'h00);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h55);
        send_item(OP_DATA, 8'hAA);
        send_item(OP_DATA, 8'h01);
        send_item(OP_DATA, 8'h80);
        send_item(OP_DATA, 8'h3C);
        send_item(OP_DATA, 8'hC3);
    endtask

    task automatic test_match_forms();
        // flag 0x10 gives pattern 0xF0: four matches then four literals
        send_item(OP_DATA, 8'h10);
        // distance one, overlapping, with a byte out of turn in the copy
        send_item(OP_DATA, 8'h12);
        send_item(OP_DATA, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_DATA, 8'hEE);
        drain_copy();
        // longest plain length code
        send_item(OP_DATA, 8'h3F);
        send_item(OP_DATA, 8'h00);
        drain_copy();
        // one extension byte
        send_item(OP_DATA, 8'h20);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        drain_copy();
        // two extension bytes
        send_item(OP_DATA, 8'h41);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h00);
        drain_copy();
        repeat (4) send_item(OP_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_stream(input int n, input logic [CNT_W-1:0] lim);
        int start;
        settle();
        write_limit(lim);
        start = n_sent;
        while (n_sent - start < n || dec_phase == PH_COPY) send_next(8);
    endtask

    task automatic test_backpressure();
        int start;
        src_idle_on  = 1'b0;
        hold_request = 1'b1;
        start = n_sent;
        while (n_sent - start < 40) send_next(8);
        src_idle_on = 1'b1;
    endtask

    task automatic test_finish();
        if ($urandom_range(0, 1)) begin
            end_reason = "input limit";
            settle();
            write_limit($urandom_range(0, 1) ? '0 :
                        dec_count + CNT_W'($urandom_range(1, 40)));
        end else begin
            end_mode = 1'b1;
        end
        while (!dec_done) send_next(8);
        // once finished, bytes are ignored and ticks do nothing
        settle();
        write_limit('0);
        repeat (20) send_item($urandom_range(0, 1) ? OP_TICK : OP_DATA,
                              8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, and one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                i_m_tready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    task automatic report(input string field, input logic [7:0] exp_v, input logic [7:0] act_v);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_decoded e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (decoded_q.size() == 0) begin
                n_errors++;
                $display("%0t: result item with nothing expected, expected none, got %0h/%0b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                e = decoded_q.pop_front();
                n_checked++;
                if (o_m_tdata[7:0] !== e.data) report("out_byte", e.data, o_m_tdata[7:0]);
                if (o_m_tuser !== e.valid) report("out_valid", 8'(e.valid), 8'(o_m_tuser));
                if (o_m_tdata[OUT_BUSY_BIT] !== e.busy)
                    report("copy_busy", 8'(e.busy), 8'(o_m_tdata[OUT_BUSY_BIT]));
                if (o_m_tdata[OUT_FIN_BIT] !== e.fin)
                    report("finished", 8'(e.fin), 8'(o_m_tdata[OUT_FIN_BIT]));
                if (o_m_tdata[OUT_MIS_BIT] !== e.misuse)
                    report("misuse", 8'(e.misuse), 8'(o_m_tdata[OUT_MIS_BIT]));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_and_literals();
        test_match_forms();
        test_random_stream(500, COUNT_MAX);
        test_random_stream(400, 24'h80_0000);
        test_backpressure();
        test_random_stream(300, CNT_W'($urandom_range(24'h01_0000, 24'h7F_FFFF)));
        // last part runs without idling
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_stream(400, COUNT_MAX);
        test_finish();

        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d items sent, %0d results checked, decoding ended by %s",
                 n_sent, n_checked, end_reason);
        $display("run: %0d literals, %0d copied bytes, %0d ignored bytes, %0d mismatches",
                 n_lit, n_copied, n_ignored, n_errors);
        if (n_errors == 0) begin
            $display("[lz_flag_group_decompressor] OK");
        end else begin
            $display("[lz_flag_group_decompressor] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
        $display("[lz_flag_group_decompressor] ERROR");
        $finish;
    end

endmodule
